### design/rhc_pkg.sv
package rhc_pkg;

   // Pixel and hue formats
   localparam int CHANNEL_BITS      = 8;
   localparam int HUE_FRACTION_BITS = 4;
   localparam int SECTOR_UNIT       = 60 * (2 ** HUE_FRACTION_BITS);
   localparam int FULL_TURN         = 6 * SECTOR_UNIT;
   localparam int HUE_BITS          = $clog2(FULL_TURN);
   localparam int UNIT_BITS         = $clog2(SECTOR_UNIT + 1);
   localparam int CHAN_FULL         = (2 ** CHANNEL_BITS) - 1;

   // Divider geometry: one quotient bit per pipeline stage
   localparam int DIV_STEPS = (CHANNEL_BITS > UNIT_BITS) ? CHANNEL_BITS : UNIT_BITS;
   localparam int REM_BITS  = CHANNEL_BITS + DIV_STEPS;

   // Which channel is largest
   localparam logic [1:0] SECTOR_RED   = 2'd0;
   localparam logic [1:0] SECTOR_GREEN = 2'd1;
   localparam logic [1:0] SECTOR_BLUE  = 2'd2;

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef logic [HUE_BITS-1:0]     hue_type;

   // After the max/min stage
   typedef struct packed {
      chan_type   hi;
      chan_type   lo;
      chan_type   minuend;
      chan_type   subtrahend;
      logic [1:0] sector;
   } front_type;

   // Travels through the divider stages
   typedef struct packed {
      logic [REM_BITS-1:0]  sat_rem;
      logic [REM_BITS-1:0]  sat_dsr;
      logic [DIV_STEPS-1:0] sat_q;
      logic [REM_BITS-1:0]  hue_rem;
      logic [REM_BITS-1:0]  hue_dsr;
      logic [DIV_STEPS-1:0] hue_q;
      logic [1:0]           sector;
      logic                 neg;
      logic                 grey;
      logic                 black;
      chan_type             bright;
   } div_type;

endpackage

### design/rhc_req_if.sv
interface rhc_req_if ();
   import rhc_pkg::*;

   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### design/rhc_rsp_if.sv
interface rhc_rsp_if ();
   import rhc_pkg::*;

   logic     valid;
   logic     ready;
   hue_type  hue;
   chan_type saturation;
   chan_type brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

### design/rgb_to_hsv_converter.sv
// RGB to HSV converter: takes one pixel per clock unless the output side stalls, and
// returns hue in sixteenths of a degree (0 to 5759), saturation (0 to 255) and value
// (the largest channel). The block is a fully pipelined chain of 13 register stages,
// and a pixel's result is presented from the output register of the last one. A new
// pixel can be taken every cycle unless the output stalls. The first stage finds max,
// min and the sector and the second sets up the dividends. One restoring divider stage
// per quotient bit (10 of them) forms saturation and hue side by side, and the last
// stage adds the sector offset into the output register. Every stage carries its own
// valid bit, so a stalled output only backs up the pipeline as far as it is full.
module rgb_to_hsv_converter (
   input  logic       clock,
   input  logic       reset,
   rhc_req_if.sink    req_bus,
   rhc_rsp_if.source  rsp_bus
);
   import rhc_pkg::*;

   logic [DIV_STEPS:0] chain_valid;
   logic [DIV_STEPS:0] chain_ready;
   div_type            chain_data [DIV_STEPS+1];

   // Max/min and dividend setup
   rhc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_red    (req_bus.red),
      .in_green  (req_bus.green),
      .in_blue   (req_bus.blue),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // One quotient bit per stage
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      rhc_div_stage u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // Sector offset, wrap and output register
   rhc_post u_post (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (chain_valid[DIV_STEPS]),
      .in_ready       (chain_ready[DIV_STEPS]),
      .in_data        (chain_data[DIV_STEPS]),
      .out_valid      (rsp_bus.valid),
      .out_ready      (rsp_bus.ready),
      .out_hue        (rsp_bus.hue),
      .out_saturation (rsp_bus.saturation),
      .out_brightness (rsp_bus.brightness)
   );

`ifndef ASSERT_OFF
   // Hue stays inside one turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.hue < HUE_BITS'(FULL_TURN)))
      else $error("hue out of range");

   // A black pixel has no saturation
   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.brightness == '0)) |-> (rsp_bus.saturation == '0))
      else $error("saturation set on black pixel");

   // Zero saturation means a grey pixel, whose hue is zero
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.saturation == '0)) |-> (rsp_bus.hue == '0))
      else $error("hue set on grey pixel");
`endif
endmodule

### design/rhc_prep.sv
module rhc_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rhc_pkg::chan_type in_red,
   input  rhc_pkg::chan_type in_green,
   input  rhc_pkg::chan_type in_blue,
   output logic              out_valid,
   input  logic              out_ready,
   output rhc_pkg::div_type  out_data
);
   import rhc_pkg::*;

   logic      front_valid_ff;
   front_type front_ff;
   front_type front_in;
   logic      front_ready;
   logic      div_valid_ff;
   div_type   div_ff;
   div_type   div_in;
   logic      div_ready;
   chan_type  span;
   logic      neg;
   chan_type  abs_diff;

   // Find largest and smallest channel and pick the difference for the sector
   always_comb begin
      front_in = '0;
      front_in.hi = in_red;
      front_in.lo = in_red;
      if (in_green > front_in.hi) front_in.hi = in_green;
      if (in_blue > front_in.hi) front_in.hi = in_blue;
      if (in_green < front_in.lo) front_in.lo = in_green;
      if (in_blue < front_in.lo) front_in.lo = in_blue;
      if (in_red == front_in.hi) begin
         front_in.sector     = SECTOR_RED;
         front_in.minuend    = in_green;
         front_in.subtrahend = in_blue;
      end else if (in_green == front_in.hi) begin
         front_in.sector     = SECTOR_GREEN;
         front_in.minuend    = in_blue;
         front_in.subtrahend = in_red;
      end else begin
         front_in.sector     = SECTOR_BLUE;
         front_in.minuend    = in_red;
         front_in.subtrahend = in_green;
      end
   end

   assign front_ready = !front_valid_ff || div_ready;
   assign in_ready    = front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_ready) begin
         front_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_ready && in_valid) begin
         front_ff <= front_in;
      end
   end

   // Build dividends and left-aligned divisors
   assign span     = front_ff.hi - front_ff.lo;
   assign neg      = front_ff.minuend < front_ff.subtrahend;
   assign abs_diff = neg ? (front_ff.subtrahend - front_ff.minuend)
                         : (front_ff.minuend - front_ff.subtrahend);

   always_comb begin
      div_in         = '0;
      div_in.sat_rem = REM_BITS'({span, CHANNEL_BITS'(0)}) - REM_BITS'(span);
      div_in.sat_dsr = REM_BITS'(front_ff.hi) << (DIV_STEPS - 1);
      div_in.hue_rem = REM_BITS'(abs_diff) * REM_BITS'(SECTOR_UNIT);
      div_in.hue_dsr = REM_BITS'(span) << (DIV_STEPS - 1);
      div_in.sector  = front_ff.sector;
      div_in.neg     = neg;
      div_in.grey    = (span == '0);
      div_in.black   = (front_ff.hi == '0);
      div_in.bright  = front_ff.hi;
   end

   assign div_ready = !div_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= 1'b0;
      end else if (div_ready) begin
         div_valid_ff <= front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready && front_valid_ff) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = div_valid_ff;
   assign out_data  = div_ff;
endmodule

### design/rhc_div_stage.sv
module rhc_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rhc_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rhc_pkg::div_type out_data
);
   import rhc_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic    sat_fits;
   logic    hue_fits;

   // Resolve one quotient bit of each divider, then move the divisors down
   assign sat_fits = in_data.sat_rem >= in_data.sat_dsr;
   assign hue_fits = in_data.hue_rem >= in_data.hue_dsr;

   always_comb begin
      data_in         = in_data;
      data_in.sat_rem = sat_fits ? (in_data.sat_rem - in_data.sat_dsr) : in_data.sat_rem;
      data_in.sat_q   = {in_data.sat_q[DIV_STEPS-2:0], sat_fits};
      data_in.sat_dsr = in_data.sat_dsr >> 1;
      data_in.hue_rem = hue_fits ? (in_data.hue_rem - in_data.hue_dsr) : in_data.hue_rem;
      data_in.hue_q   = {in_data.hue_q[DIV_STEPS-2:0], hue_fits};
      data_in.hue_dsr = in_data.hue_dsr >> 1;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

### design/rhc_post.sv
module rhc_post (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rhc_pkg::div_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rhc_pkg::hue_type  out_hue,
   output rhc_pkg::chan_type out_saturation,
   output rhc_pkg::chan_type out_brightness
);
   import rhc_pkg::*;

   logic              valid_ff;
   hue_type           hue_ff;
   hue_type           hue_in;
   chan_type          sat_ff;
   chan_type          sat_in;
   chan_type          bright_ff;
   logic [HUE_BITS:0] base;
   logic [HUE_BITS:0] quot;

   // Sector offset
   always_comb begin
      case (in_data.sector)
         SECTOR_RED:   base = '0;
         SECTOR_GREEN: base = (HUE_BITS + 1)'(2 * SECTOR_UNIT);
         SECTOR_BLUE:  base = (HUE_BITS + 1)'(4 * SECTOR_UNIT);
         default:      base = '0;
      endcase
   end

   assign quot = (HUE_BITS + 1)'(in_data.hue_q);

   // Apply the signed quotient and wrap a negative hue by one turn
   always_comb begin
      if (in_data.grey) begin
         hue_in = '0;
      end else if (in_data.neg && (quot > base)) begin
         hue_in = HUE_BITS'(base + (HUE_BITS + 1)'(FULL_TURN) - quot);
      end else if (in_data.neg) begin
         hue_in = HUE_BITS'(base - quot);
      end else begin
         hue_in = HUE_BITS'(base + quot);
      end
   end

   assign sat_in = in_data.black ? '0 : in_data.sat_q[CHANNEL_BITS-1:0];

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= in_data.bright;
      end
   end

   assign out_valid      = valid_ff;
   assign out_hue        = hue_ff;
   assign out_saturation = sat_ff;
   assign out_brightness = bright_ff;
endmodule
